// ----- design/clw_pkg.sv -----
// ----------------------------------------------------------------------------
// clw_pkg: shared types, codes and geometry tables
// Item structs, command codes, job format between the front and back parts,
// and the display geometry tables for the character LCD writer.
// ----------------------------------------------------------------------------
package clw_pkg;

    localparam int GEO_W      = 3;
    localparam int COL_W      = 6;
    localparam int ROW_W      = 2;
    localparam int STEP_W     = 3;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Command codes.
    localparam logic [2:0] CMD_CHAR      = 3'd0;
    localparam logic [2:0] CMD_SETPOS    = 3'd1;
    localparam logic [2:0] CMD_CURSOR    = 3'd2;
    localparam logic [2:0] CMD_BLINK     = 3'd3;
    localparam logic [2:0] CMD_BACKLIGHT = 3'd4;
    localparam logic [2:0] CMD_CLEAR     = 3'd5;
    localparam logic [2:0] CMD_HOME      = 3'd6;

    // Special character codes.
    localparam logic [7:0] CH_BACKSPACE = 8'd8;
    localparam logic [7:0] CH_NEWLINE   = 8'd10;
    localparam logic [7:0] CH_RETURN    = 8'd13;

    // LCD opcodes.
    localparam logic [7:0] OP_CLEAR   = 8'h01;
    localparam logic [7:0] OP_HOME    = 8'h02;
    localparam logic [5:0] OP_DISPCTL = 6'b000011;
    localparam logic [7:0] BL_BYTE_ON = 8'h08;

    // Geometry codes.
    localparam logic [2:0] GEO_40X2 = 3'd0;
    localparam logic [2:0] GEO_20X4 = 3'd1;
    localparam logic [2:0] GEO_20X2 = 3'd2;
    localparam logic [2:0] GEO_16X4 = 3'd3;
    localparam logic [2:0] GEO_16X2 = 3'd4;
    localparam logic [2:0] GEO_8X2  = 3'd5;
    localparam logic [2:0] GEO_MAX  = GEO_8X2;
    localparam logic [2:0] GEO_RESET = GEO_20X4;

    // Job modes: a raw single bus byte, one LCD byte, or two LCD bytes.
    localparam logic [1:0] JOB_RAW = 2'd0;
    localparam logic [1:0] JOB_ONE = 2'd1;
    localparam logic [1:0] JOB_TWO = 2'd2;

    typedef struct packed {
        logic [2:0] command;
        logic [7:0] char_code;
        logic [7:0] column_in;
        logic [7:0] row_in;
        logic       flag;
    } t_in_item;

    typedef struct packed {
        logic [7:0]       bus_byte;
        logic             last;
        logic [COL_W-1:0] cursor_column;
        logic [ROW_W-1:0] cursor_row;
    } t_out_item;

    typedef struct packed {
        logic [1:0]       mode;
        logic [7:0]       byte0;
        logic [7:0]       byte1;
        logic             rs1;
        logic             light;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
    } t_job;

    function automatic logic four_rows(input logic [GEO_W-1:0] g);
        return (g == GEO_20X4) || (g == GEO_16X4);
    endfunction

    function automatic logic [COL_W-1:0] geo_cols(input logic [GEO_W-1:0] g);
        logic [COL_W-1:0] c;
        case (g) inside
            GEO_40X2:           c = 6'd40;
            GEO_16X4, GEO_16X2: c = 6'd16;
            GEO_8X2:            c = 6'd8;
            default:            c = 6'd20;
        endcase
        return c;
    endfunction

    // Row base addresses in display memory.
    function automatic logic [6:0] geo_base(input logic [GEO_W-1:0] g,
                                            input logic [ROW_W-1:0] r);
        logic [6:0] b;
        case (r)
            2'd0: b = 7'h00;
            2'd1: b = 7'h40;
            2'd2: b = (g == GEO_20X4) ? 7'h14 : ((g == GEO_16X4) ? 7'h10 : 7'h00);
            default: begin
                case (g) inside
                    GEO_20X4: b = 7'h54;
                    GEO_16X4: b = 7'h50;
                    GEO_8X2:  b = 7'h40;
                    default:  b = 7'h00;
                endcase
            end
        endcase
        return b;
    endfunction

    // Column modulo the column count; the value never exceeds 40.
    function automatic logic [COL_W-1:0] mod_cols(input logic [COL_W-1:0] v,
                                                  input logic [GEO_W-1:0] g);
        logic [COL_W-1:0] m;
        case (g) inside
            GEO_40X2:           m = (v >= 6'd40) ? v - 6'd40 : v;
            GEO_16X4, GEO_16X2: m = {2'b00, v[3:0]};
            GEO_8X2:            m = {3'b000, v[2:0]};
            default: begin
                if (v >= 6'd40) begin
                    m = v - 6'd40;
                end else if (v >= 6'd20) begin
                    m = v - 6'd20;
                end else begin
                    m = v;
                end
            end
        endcase
        return m;
    endfunction

    function automatic logic [ROW_W-1:0] mod_rows(input logic [ROW_W-1:0] r,
                                                  input logic [GEO_W-1:0] g);
        return four_rows(g) ? r : {1'b0, r[0]};
    endfunction

    function automatic logic [ROW_W-1:0] next_row(input logic [ROW_W-1:0] r,
                                                  input logic [GEO_W-1:0] g);
        return four_rows(g) ? r + 2'd1 : {1'b0, ~r[0]};
    endfunction

    function automatic logic [7:0] lcd_addr(input logic [COL_W-1:0] col,
                                            input logic [ROW_W-1:0] row,
                                            input logic [GEO_W-1:0] g);
        logic [6:0] s;
        s = {1'b0, mod_cols(col, g)} + geo_base(g, mod_rows(row, g));
        return {1'b1, s};
    endfunction

    function automatic logic [STEP_W-1:0] last_step(input logic [1:0] mode);
        logic [STEP_W-1:0] s;
        unique case (mode)
            JOB_RAW: s = 3'd0;
            JOB_ONE: s = 3'd3;
            default: s = 3'd7;
        endcase
        return s;
    endfunction

endpackage

// ----- design/clw_front.sv -----
// ----------------------------------------------------------------------------
// clw_front: command decode and cursor state
// Accepts commands, updates cursor, flags and geometry, and queues a job
// that describes the bytes to send for each command that sends any.
// ----------------------------------------------------------------------------
module clw_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [clw_pkg::GEO_W-1:0]   i_cfg_wdata,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  clw_pkg::t_in_item           i_in_data,
    output logic                        o_push,
    output clw_pkg::t_job               o_job,
    input  logic                        i_full
);
    import clw_pkg::*;

    logic [GEO_W-1:0] r_geometry;
    logic [COL_W-1:0] r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;
    logic             r_cursor, n_cursor;
    logic             r_blink, n_blink;
    logic             r_light, n_light;

    logic             accept;
    logic             want_push;
    logic [COL_W-1:0] cols;
    logic [COL_W-1:0] inc_col;
    logic [COL_W-1:0] place_col;
    logic [ROW_W-1:0] place_row;
    logic [7:0]       place_addr;
    logic [7:0]       ch;

    assign o_in_stall = i_full;
    assign accept     = i_in_valid && !i_full;
    assign o_push     = accept && want_push;
    assign ch         = i_in_data.char_code;
    assign cols       = geo_cols(r_geometry);
    assign inc_col    = mod_cols(r_col + 6'd1, r_geometry);

    // Placement clamps out-of-range coordinates to zero, for both set position
    // and clear.
    always_comb begin
        if (i_in_data.command == CMD_SETPOS) begin
            place_col = (i_in_data.column_in >= {2'b00, cols}) ?
                        '0 : i_in_data.column_in[COL_W-1:0];
            place_row = (i_in_data.row_in >= (four_rows(r_geometry) ? 8'd4 : 8'd2)) ?
                        '0 : i_in_data.row_in[ROW_W-1:0];
        end else begin
            place_col = (r_col >= cols) ? '0 : r_col;
            place_row = (!four_rows(r_geometry) && r_row[1]) ? '0 : r_row;
        end
        place_addr = lcd_addr(place_col, place_row, r_geometry);
    end

    always_comb begin
        n_col     = r_col;
        n_row     = r_row;
        n_cursor  = r_cursor;
        n_blink   = r_blink;
        n_light   = r_light;
        want_push = 1'b0;
        o_job     = '0;
        unique case (i_in_data.command)
            CMD_CHAR: begin
                if (ch == CH_NEWLINE || ch == CH_RETURN) begin
                    n_col = '0;
                    n_row = next_row(r_row, r_geometry);
                end else if (ch == CH_BACKSPACE) begin
                    if (r_col != '0) begin
                        n_col = r_col - 6'd1;
                    end
                end else begin
                    want_push   = 1'b1;
                    o_job.mode  = JOB_TWO;
                    o_job.byte0 = lcd_addr(r_col, r_row, r_geometry);
                    o_job.byte1 = ch;
                    o_job.rs1   = 1'b1;
                    n_col       = inc_col;
                    if (inc_col == '0) begin
                        n_row = next_row(r_row, r_geometry);
                    end
                end
            end
            CMD_SETPOS: begin
                want_push   = 1'b1;
                o_job.mode  = JOB_ONE;
                o_job.byte0 = place_addr;
                n_col       = place_col;
                n_row       = place_row;
            end
            CMD_CURSOR: begin
                want_push   = 1'b1;
                n_cursor    = i_in_data.flag;
                o_job.mode  = JOB_ONE;
                o_job.byte0 = {OP_DISPCTL, i_in_data.flag, r_blink};
            end
            CMD_BLINK: begin
                want_push   = 1'b1;
                n_blink     = i_in_data.flag;
                o_job.mode  = JOB_ONE;
                o_job.byte0 = {OP_DISPCTL, r_cursor, i_in_data.flag};
            end
            CMD_BACKLIGHT: begin
                want_push   = 1'b1;
                n_light     = i_in_data.flag;
                o_job.mode  = JOB_RAW;
                o_job.byte0 = i_in_data.flag ? BL_BYTE_ON : 8'h00;
            end
            CMD_CLEAR: begin
                want_push   = 1'b1;
                o_job.mode  = JOB_TWO;
                o_job.byte0 = OP_CLEAR;
                o_job.byte1 = place_addr;
                n_col       = place_col;
                n_row       = place_row;
            end
            CMD_HOME: begin
                want_push   = 1'b1;
                o_job.mode  = JOB_ONE;
                o_job.byte0 = OP_HOME;
                n_col       = '0;
                n_row       = '0;
            end
            default: begin
                want_push = 1'b0;
            end
        endcase
        o_job.light = n_light;
        o_job.col   = n_col;
        o_job.row   = n_row;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_geometry <= GEO_RESET;
            r_col      <= '0;
            r_row      <= '0;
            r_cursor   <= 1'b0;
            r_blink    <= 1'b0;
            r_light    <= 1'b1;
        end else begin
            if (i_cfg_we && i_cfg_wdata <= GEO_MAX) begin
                r_geometry <= i_cfg_wdata;
            end
            if (accept) begin
                r_col    <= n_col;
                r_row    <= n_row;
                r_cursor <= n_cursor;
                r_blink  <= n_blink;
                r_light  <= n_light;
            end
        end
    end

    a_geo_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_geometry <= GEO_MAX)
        else $error("geometry register holds an unsupported code");

    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_col < 6'd40)
        else $error("cursor column beyond the widest geometry");

endmodule

// ----- design/clw_queue.sv -----
// ----------------------------------------------------------------------------
// clw_queue: job queue
// Short first-in first-out queue that decouples command decode from the
// bus byte sequencer.
// ----------------------------------------------------------------------------
module clw_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  clw_pkg::t_job  i_job,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_head_valid,
    output clw_pkg::t_job  o_head
);
    import clw_pkg::*;

    t_job              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    assign o_full       = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond its depth");

    a_count_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue count did not follow a transfer in");

endmodule

// ----- design/clw_back.sv -----
// ----------------------------------------------------------------------------
// clw_back: bus byte sequencer
// Walks the queued job one bus byte per cycle unless the output stalls: a raw job's
// byte as is, else high then low nibble of each LCD byte, each as an enable-high byte then an enable-low one.
// ----------------------------------------------------------------------------
module clw_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_head_valid,
    input  clw_pkg::t_job      i_head,
    output logic               o_pop,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output clw_pkg::t_out_item o_out_data
);
    import clw_pkg::*;

    logic [STEP_W-1:0] r_step;
    logic              r_out_valid;
    t_out_item         r_out, n_out;

    logic              adv;
    logic              step_last;
    logic [7:0]        sel_byte;
    logic [3:0]        nib;

    assign adv       = !r_out_valid || !i_out_stall;
    assign step_last = (r_step == last_step(i_head.mode));
    assign o_pop     = adv && i_head_valid && step_last;

    always_comb begin
        sel_byte = r_step[2] ? i_head.byte1 : i_head.byte0;
        nib      = r_step[1] ? sel_byte[3:0] : sel_byte[7:4];
        if (i_head.mode == JOB_RAW) begin
            n_out.bus_byte = i_head.byte0;
        end else begin
            n_out.bus_byte = {nib, i_head.light, ~r_step[0], 1'b0, r_step[2] & i_head.rs1};
        end
        n_out.last          = step_last;
        n_out.cursor_column = i_head.col;
        n_out.cursor_row    = i_head.row;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_step      <= '0;
        end else if (adv) begin
            r_out_valid <= i_head_valid;
            if (i_head_valid) begin
                r_step <= step_last ? '0 : r_step + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && i_head_valid) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_step_has_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step != '0) |-> i_head_valid)
        else $error("sequencer mid-job with an empty queue");

    a_pop_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_step == '0))
        else $error("sequencer did not restart after finishing a job");

endmodule

// ----- design/char_lcd_text_stream_writer.sv -----
// ----------------------------------------------------------------------------
// char_lcd_text_stream_writer: character LCD text stream writer
// Converts text and control commands into port expander bytes for a 4-bit
// character LCD and tracks the cursor for the selected geometry.
// ----------------------------------------------------------------------------
// The first bus byte of a command is registered in the job queue, then in the back-end
// sequencer's output register. Throughput: one bus byte per cycle unless the output stalls;
// a character or clear sends two LCD bytes, set position, cursor, blink and home one,
// backlight one raw bus byte, newline/backspace none; a two-entry job queue lets
// commands enter while earlier ones are still being sent.
// Reset (synchronous, active low): cursor at 0/0, cursor and blink off,
// backlight on, geometry 20x4, queue and output empty.
module char_lcd_text_stream_writer (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [clw_pkg::GEO_W-1:0]  i_cfg_wdata,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  clw_pkg::t_in_item          i_in_data,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output clw_pkg::t_out_item         o_out_data
);
    import clw_pkg::*;

    logic push;
    logic pop;
    logic full;
    logic head_valid;
    t_job job;
    t_job head;

    clw_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_push      (push),
        .o_job       (job),
        .i_full      (full)
    );

    clw_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_job        (job),
        .o_full       (full),
        .i_pop        (pop),
        .o_head_valid (head_valid),
        .o_head       (head)
    );

    clw_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head       (head),
        .o_pop        (pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_data   (o_out_data)
    );

endmodule

// ----- dv/char_lcd_text_stream_writer_test.sv -----
// ----------------------------------------------------------------------------
// char_lcd_text_stream_writer_test: self-checking testbench
// Sends text and control commands through the input channel and checks
// every expander bus byte against a cycle-free prediction of the LCD
// traffic and cursor tracking. It covers directed corner cases, a sweep of
// all display geometries, a long random stream and a long output hold-off.
// ----------------------------------------------------------------------------
module char_lcd_text_stream_writer_test;
    timeunit 1ns;
    timeprecision 1ps;
    import clw_pkg::*;

    localparam int CLK_HALF      = 2;
    localparam int TIMEOUT_NS    = 400_000;
    localparam int SETTLE_CYCLES = 20;
    localparam int HOLD_CYCLES   = 200;
    localparam int RANDOM_ITEMS  = 75;

    localparam logic [2:0] CMD_UNUSED   = 3'd7;
    localparam logic [2:0] GEO_INVALID6 = 3'd6;
    localparam logic [2:0] GEO_INVALID7 = 3'd7;

    localparam logic [7:0] LCD_SET_ADDR  = 8'h80;
    localparam logic [7:0] LCD_DISP_CTRL = 8'h0C;
    localparam logic [7:0] EXP_RS        = 8'h01;
    localparam logic [7:0] EXP_EN        = 8'h04;
    localparam logic [7:0] EXP_BL        = 8'h08;

    logic             i_clk       = 1'b0;
    logic             i_rst_n     = 1'b0;
    logic             i_cfg_we    = 1'b0;
    logic [GEO_W-1:0] i_cfg_wdata = '0;
    logic             i_in_valid  = 1'b0;
    logic             o_in_stall;
    t_in_item         i_in_data   = '0;
    logic             o_out_valid;
    logic             i_out_stall = 1'b0;
    t_out_item        o_out_data;

    // Predicted display state.
    logic [2:0] geo_sel   = GEO_RESET;
    int         cur_col   = 0;
    int         cur_row   = 0;
    logic       cursor_on = 1'b0;
    logic       blink_on  = 1'b0;
    logic       light_on  = 1'b1;

    logic [7:0] frame_bytes[$];
    t_out_item  expected_bus[$];
    int         error_count = 0;
    int         idle_pct    = 21;
    int         hold_token  = 0;
    int         hold_seen   = 0;
    int         hold_left   = 0;

    char_lcd_text_stream_writer u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    initial begin
        forever #(CLK_HALF) i_clk = ~i_clk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic int cols_of(input logic [2:0] g);
        case (g) inside
            GEO_40X2:           return 40;
            GEO_20X4, GEO_20X2: return 20;
            GEO_16X4, GEO_16X2: return 16;
            default:            return 8;
        endcase
    endfunction

    function automatic int rows_of(input logic [2:0] g);
        return (g == GEO_20X4 || g == GEO_16X4) ? 4 : 2;
    endfunction

    function automatic int row_base(input logic [2:0] g, input int r);
        case (r)
            0: return 8'h00;
            1: return 8'h40;
            2: return (g == GEO_20X4) ? 8'h14 : ((g == GEO_16X4) ? 8'h10 : 8'h00);
            default: begin
                if (g == GEO_20X4) begin
                    return 8'h54;
                end else if (g == GEO_16X4) begin
                    return 8'h50;
                end else if (g == GEO_8X2) begin
                    return 8'h40;
                end
                return 8'h00;
            end
        endcase
    endfunction

    // One LCD byte goes out as two nibbles, each strobed enable high then low.
    function automatic void add_lcd_byte(input logic [7:0] value, input logic rs);
        logic [7:0] b;
        for (int half = 0; half < 2; half++) begin
            b = (half == 0) ? {value[7:4], 4'h0} : {value[3:0], 4'h0};
            b = b | (light_on ? EXP_BL : 8'h00) | (rs ? EXP_RS : 8'h00);
            frame_bytes.push_back(b | EXP_EN);
            frame_bytes.push_back(b);
        end
    endfunction

    // The cursor may lie outside the geometry after a change; wrap it here.
    function automatic void add_address();
        int c;
        int r;
        c = cur_col % cols_of(geo_sel);
        r = (cur_row % rows_of(geo_sel)) & 3;
        add_lcd_byte(8'(LCD_SET_ADDR | ((c + row_base(geo_sel, r)) & 8'h7F)), 1'b0);
    endfunction

    function automatic void move_cursor(input int col, input int row);
        cur_col = (col >= cols_of(geo_sel)) ? 0 : col;
        cur_row = (row >= rows_of(geo_sel)) ? 0 : row;
        add_address();
    endfunction

    function automatic void predict_bus_bytes(input t_in_item it);
        int        cols;
        int        rows;
        t_out_item e;
        cols = cols_of(geo_sel);
        rows = rows_of(geo_sel);
        frame_bytes.delete();
        case (it.command)
            CMD_CHAR: begin
                if (it.char_code == CH_NEWLINE || it.char_code == CH_RETURN) begin
                    cur_col = 0;
                    cur_row = (cur_row + 1) % rows;
                end else if (it.char_code == CH_BACKSPACE) begin
                    if (cur_col > 0) begin
                        cur_col--;
                    end
                end else begin
                    add_address();
                    add_lcd_byte(it.char_code, 1'b1);
                    cur_col = (cur_col + 1) % cols;
                    if (cur_col == 0) begin
                        cur_row = (cur_row + 1) % rows;
                    end
                end
            end
            CMD_SETPOS: move_cursor(int'(it.column_in), int'(it.row_in));
            CMD_CURSOR: begin
                cursor_on = it.flag;
                add_lcd_byte(LCD_DISP_CTRL | {6'b0, cursor_on, blink_on}, 1'b0);
            end
            CMD_BLINK: begin
                blink_on = it.flag;
                add_lcd_byte(LCD_DISP_CTRL | {6'b0, cursor_on, blink_on}, 1'b0);
            end
            CMD_BACKLIGHT: begin
                light_on = it.flag;
                frame_bytes.push_back(light_on ? BL_BYTE_ON : 8'h00);
            end
            CMD_CLEAR: begin
                add_lcd_byte(OP_CLEAR, 1'b0);
                move_cursor(cur_col, cur_row);
            end
            CMD_HOME: begin
                cur_col = 0;
                cur_row = 0;
                add_lcd_byte(OP_HOME, 1'b0);
            end
            default: ;
        endcase
        foreach (frame_bytes[k]) begin
            e.bus_byte      = frame_bytes[k];
            e.last          = (k == frame_bytes.size() - 1);
            e.cursor_column = cur_col[COL_W-1:0];
            e.cursor_row    = cur_row[ROW_W-1:0];
            expected_bus.push_back(e);
        end
    endfunction

    function automatic t_in_item lcd_cmd(input logic [2:0] cmd, input logic [7:0] ch,
                                         input logic [7:0] col, input logic [7:0] row,
                                         input logic flag);
        t_in_item it;
        it.command   = cmd;
        it.char_code = ch;
        it.column_in = col;
        it.row_in    = row;
        it.flag      = flag;
        return it;
    endfunction

    function automatic t_in_item random_lcd_cmd();
        t_in_item it;
        int       pick;
        it   = lcd_cmd(CMD_CHAR, 8'($urandom_range(255)), 8'($urandom_range(255)),
                       8'($urandom_range(255)), 1'($urandom_range(1)));
        pick = $urandom_range(99);
        if (pick < 40) begin
            it.command = CMD_CHAR;
        end else if (pick < 44) begin
            it.char_code = (pick < 42) ? CH_NEWLINE : CH_RETURN;
        end else if (pick < 47) begin
            it.char_code = CH_BACKSPACE;
        end else if (pick < 60) begin
            it.command = CMD_SETPOS;
            // Mostly near the valid range, boundary included, else anything.
            if ($urandom_range(3) != 0) begin
                it.column_in = 8'($urandom_range(cols_of(geo_sel)));
                it.row_in    = 8'($urandom_range(rows_of(geo_sel)));
            end
        end else if (pick < 67) begin
            it.command = CMD_CURSOR;
        end else if (pick < 74) begin
            it.command = CMD_BLINK;
        end else if (pick < 81) begin
            it.command = CMD_BACKLIGHT;
        end else if (pick < 89) begin
            it.command = CMD_CLEAR;
        end else if (pick < 96) begin
            it.command = CMD_HOME;
        end else begin
            it.command = CMD_UNUSED;
        end
        return it;
    endfunction

    // Called at a clock edge; returns at the edge where the transfer happened.
    task automatic send_cmd(input t_in_item it);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (o_in_stall);
        predict_bus_bytes(it);
    endtask

    // Newline and backspace leave nothing to wait on, hence the extra cycles.
    task automatic settle();
        i_in_valid <= 1'b0;
        while (expected_bus.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_geometry(input logic [2:0] g);
        settle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= g;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (g <= GEO_MAX) begin
            geo_sel = g;
        end
    endtask

    task automatic test_text_basics();
        send_cmd(lcd_cmd(CMD_CHAR, 8'h48, 8'h00, 8'h00, 1'b0));
        send_cmd(lcd_cmd(CMD_CHAR, 8'h00, 8'h00, 8'h00, 1'b0));
        send_cmd(lcd_cmd(CMD_CHAR, 8'hFF, 8'h00, 8'h00, 1'b0));
        send_cmd(lcd_cmd(CMD_CHAR, CH_BACKSPACE, 8'h00, 8'h00, 1'b0));
        send_cmd(lcd_cmd(CMD_CHAR, CH_NEWLINE, 8'h00, 8'h00, 1'b0));
        send_cmd(lcd_cmd(CMD_CHAR, CH_RETURN, 8'h00, 8'h00, 1'b0));
        send_cmd(lcd_cmd(CMD_CHAR, CH_BACKSPACE, 8'h00, 8'h00, 1'b0));
        send_cmd(lcd_cmd(CMD_SETPOS, 8'h00, 8'd19, 8'd3, 1'b0));
        send_cmd(lcd_cmd(CMD_CHAR, 8'h7E, 8'h00, 8'h00, 1'b0));
        send_cmd(lcd_cmd(CMD_SETPOS, 8'h00, 8'hFF, 8'hFF, 1'b0));
        send_cmd(lcd_cmd(CMD_SETPOS, 8'h00, 8'd20, 8'd4, 1'b0));
        send_cmd(lcd_cmd(CMD_SETPOS, 8'h00, 8'd5, 8'd2, 1'b0));
        send_cmd(lcd_cmd(CMD_CURSOR, 8'h00, 8'h00, 8'h00, 1'b1));
        send_cmd(lcd_cmd(CMD_BLINK, 8'h00, 8'h00, 8'h00, 1'b1));
        send_cmd(lcd_cmd(CMD_CURSOR, 8'h00, 8'h00, 8'h00, 1'b0));
        send_cmd(lcd_cmd(CMD_BLINK, 8'h00, 8'h00, 8'h00, 1'b0));
        send_cmd(lcd_cmd(CMD_BACKLIGHT, 8'h00, 8'h00, 8'h00, 1'b0));
        send_cmd(lcd_cmd(CMD_CHAR, 8'h5A, 8'h00, 8'h00, 1'b0));
        send_cmd(lcd_cmd(CMD_CLEAR, 8'h00, 8'h00, 8'h00, 1'b0));
        send_cmd(lcd_cmd(CMD_BACKLIGHT, 8'h00, 8'h00, 8'h00, 1'b1));
        send_cmd(lcd_cmd(CMD_HOME, 8'h00, 8'h00, 8'h00, 1'b0));
        send_cmd(lcd_cmd(CMD_UNUSED, 8'hFF, 8'hFF, 8'hFF, 1'b1));
        send_cmd(lcd_cmd(CMD_CLEAR, 8'h00, 8'h00, 8'h00, 1'b0));
    endtask

    // Each phase leaves the cursor in the far corner, so the next geometry
    // starts with a cursor that may lie outside it.
    task automatic test_geometry_sweep();
        logic [2:0] sweep[10];
        int         cols;
        int         rows;
        sweep = '{GEO_40X2, GEO_8X2, GEO_20X4, GEO_16X4, GEO_INVALID6,
                  GEO_16X2, GEO_20X2, GEO_INVALID7, GEO_40X2, GEO_8X2};
        for (int p = 0; p < 10; p++) begin
            write_geometry(sweep[p]);
            cols = cols_of(geo_sel);
            rows = rows_of(geo_sel);
            if (p % 2 == 0) begin
                send_cmd(lcd_cmd(CMD_CHAR, 8'($urandom_range(32, 126)), 8'h00, 8'h00,
                                 1'b0));
            end else begin
                send_cmd(lcd_cmd(CMD_CLEAR, 8'h00, 8'h00, 8'h00, 1'b0));
            end
            send_cmd(lcd_cmd(CMD_SETPOS, 8'h00, 8'(cols - 1), 8'(rows - 1), 1'b0));
            send_cmd(lcd_cmd(CMD_CHAR, 8'($urandom_range(32, 126)), 8'h00, 8'h00, 1'b0));
            send_cmd(lcd_cmd(CMD_CHAR, 8'($urandom_range(32, 126)), 8'h00, 8'h00, 1'b0));
            send_cmd(lcd_cmd(CMD_CHAR, CH_NEWLINE, 8'h00, 8'h00, 1'b0));
            send_cmd(lcd_cmd(CMD_CHAR, CH_BACKSPACE, 8'h00, 8'h00, 1'b0));
            send_cmd(lcd_cmd(CMD_SETPOS, 8'h00, 8'(cols - 1), 8'(rows - 1), 1'b0));
        end
    endtask

    task automatic test_random_stream();
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i % 25 == 24) begin
                write_geometry(3'($urandom_range(7)));
            end
            if (i == 20) begin
                idle_pct = 0;
            end else if (i == 55) begin
                idle_pct = 21;
            end
            send_cmd(random_lcd_cmd());
        end
    endtask

    // The receiver stops for a long stretch while characters keep coming,
    // so the job queue fills and the input stalls.
    task automatic test_output_hold_off();
        settle();
        hold_token++;
        repeat (12) begin
            send_cmd(lcd_cmd(CMD_CHAR, 8'($urandom_range(32, 126)), 8'h00, 8'h00, 1'b0));
        end
    endtask

    always @(posedge i_clk) begin
        if (hold_seen != hold_token) begin
            hold_seen   <= hold_token;
            hold_left   <= HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_bus.size() == 0) begin
                error_count++;
                $error("bus byte %h transferred with nothing pending", o_out_data.bus_byte);
            end else begin
                want = expected_bus.pop_front();
                if (o_out_data.bus_byte !== want.bus_byte) begin
                    error_count++;
                    $error("bus_byte: expected %h, got %h", want.bus_byte,
                           o_out_data.bus_byte);
                end
                if (o_out_data.last !== want.last) begin
                    error_count++;
                    $error("last: expected %b, got %b", want.last, o_out_data.last);
                end
                if (o_out_data.cursor_column !== want.cursor_column) begin
                    error_count++;
                    $error("cursor_column: expected %0d, got %0d", want.cursor_column,
                           o_out_data.cursor_column);
                end
                if (o_out_data.cursor_row !== want.cursor_row) begin
                    error_count++;
                    $error("cursor_row: expected %0d, got %0d", want.cursor_row,
                           o_out_data.cursor_row);
                end
            end
        end
    end

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_text_basics();
        test_geometry_sweep();
        test_random_stream();
        test_output_hold_off();
        settle();
        if (error_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
